>>> sv/nsp_pkg.sv
// Shared types and character constants for the number string parser.
// No dependencies; imported by number_string_parser.
`default_nettype none

package nsp_pkg;

   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned OFFSET_W = 16;
   localparam int unsigned BASE_W   = 6;
   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned DIGIT_W  = 6;

   localparam logic [CHAR_W-1:0]  CHAR_NUL    = 8'h00;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0]  CHAR_NINE   = 8'h39;
   localparam logic [CHAR_W-1:0]  CHAR_LOW_A  = 8'h61;
   localparam logic [CHAR_W-1:0]  CHAR_LOW_X  = 8'h78;
   localparam logic [CHAR_W-1:0]  CHAR_LOW_Z  = 8'h7A;
   localparam logic [CHAR_W-1:0]  CHAR_UP_A   = 8'h41;
   localparam logic [CHAR_W-1:0]  CHAR_UP_Z   = 8'h5A;

   localparam logic [BASE_W-1:0]  BASE_TEN     = 6'd10;
   localparam logic [BASE_W-1:0]  BASE_SIXTEEN = 6'd16;
   localparam logic [DIGIT_W-1:0] LETTER_BIAS  = 6'd10;

   localparam logic [OFFSET_W-1:0] OFFSET_MAX   = {OFFSET_W{1'b1}};
   localparam logic [OFFSET_W-1:0] OFFSET_AFTER_PREFIX = 16'd2;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_BAD_CHAR  = 2'd2,
      STATUS_BIG_DIGIT = 2'd3
   } status_type;

endpackage

`default_nettype wire

>>> sv/number_string_parser.sv
// Streaming unsigned-number parser: one character per beat in, one result per string out.
// Depends on nsp_pkg for character constants and the status type.
//
//  channel  | direction | ports                                      | handshake
//  ---------+-----------+--------------------------------------------+-----------
//  req      | in        | req_ch                                     | valid/ready
//  rsp      | out       | rsp_value, rsp_status, rsp_end_offset      | valid/ready
//  csr      | in        | csr_wr_data                                | write enable
//
// One character is taken per clock cycle but for the stall below; the parse step (a 32 by 6 bit
// multiply-add) sits between the input register and the result register, so the beat that ends
// or breaks the string passes through both registers before its result is presented.
// A character that produces no result moves on even while the result register is held;
// a character that produces a result waits until the held result has been taken.
// Synchronous active-high reset clears the parse state and the base register to zero.
`default_nettype none

module number_string_parser (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [nsp_pkg::CHAR_W-1:0]    req_ch,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [nsp_pkg::VALUE_W-1:0]        rsp_value,
   output logic [1:0]                         rsp_status,
   output logic [nsp_pkg::OFFSET_W-1:0]       rsp_end_offset,
   input  wire logic                          csr_wr_en,
   input  wire logic [nsp_pkg::BASE_W-1:0]    csr_wr_data
);
   import nsp_pkg::*;

   logic [BASE_W-1:0]   base_reg_ff;
   logic                in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0]   ch_ff;

   logic [VALUE_W-1:0]  accum_ff, accum_in;
   logic [BASE_W-1:0]   active_base_ff, active_base_in;
   logic [OFFSET_W-1:0] position_ff, position_in;
   logic                first_was_zero_ff, first_was_zero_in;
   logic                skipping_ff, skipping_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff;
   status_type          rsp_status_ff;
   logic [OFFSET_W-1:0] rsp_offset_ff;

   logic                emit;
   status_type          status_in;
   logic                fire, out_free, req_accept;
   logic [BASE_W-1:0]   base_now;
   logic                prefix, is_dec, is_low, is_up;
   logic [DIGIT_W-1:0]  digit;
   logic [VALUE_W+BASE_W-1:0] product;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign fire       = in_valid_ff && (!emit || out_free);
   assign req_ready  = !in_valid_ff || fire;
   assign req_accept = req_valid && req_ready;

   // Base is taken from the register on a string's first character (ten if zero); a 0x prefix sets sixteen.
   assign base_now = (position_ff == '0)
                     ? ((base_reg_ff != '0) ? base_reg_ff : BASE_TEN)
                     : active_base_ff;
   assign prefix   = first_was_zero_ff && (position_ff == OFFSET_W'(1))
                     && (ch_ff == CHAR_LOW_X);
   assign is_dec   = (ch_ff >= CHAR_ZERO)  && (ch_ff <= CHAR_NINE);
   assign is_low   = (ch_ff >= CHAR_LOW_A) && (ch_ff <= CHAR_LOW_Z);
   assign is_up    = (ch_ff >= CHAR_UP_A)  && (ch_ff <= CHAR_UP_Z);

   always_comb begin
      logic [CHAR_W-1:0] diff;
      diff = '0;
      if (is_dec) begin
         diff = ch_ff - CHAR_ZERO;
      end else if (is_low) begin
         diff = ch_ff - CHAR_LOW_A;
      end else if (is_up) begin
         diff = ch_ff - CHAR_UP_A;
      end
      digit = diff[DIGIT_W-1:0] + ((is_dec) ? DIGIT_W'(0) : LETTER_BIAS);
   end

   assign product = accum_ff * base_now;

   always_comb begin
      accum_in          = accum_ff;
      active_base_in    = active_base_ff;
      position_in       = position_ff;
      first_was_zero_in = first_was_zero_ff;
      skipping_in       = skipping_ff;
      emit              = 1'b0;
      status_in         = STATUS_OK;
      if (skipping_ff) begin
         if (ch_ff == CHAR_NUL) begin
            accum_in       = '0;
            active_base_in = '0;
            position_in    = '0;
            skipping_in    = 1'b0;
         end
      end else if (ch_ff == CHAR_NUL) begin
         emit           = 1'b1;
         status_in      = (position_ff == '0) ? STATUS_EMPTY : STATUS_OK;
         accum_in       = '0;
         active_base_in = '0;
         position_in    = '0;
         first_was_zero_in = 1'b0;
      end else begin
         active_base_in    = base_now;
         first_was_zero_in = 1'b0;
         if (prefix) begin
            active_base_in = BASE_SIXTEEN;
            accum_in       = '0;
            position_in    = OFFSET_AFTER_PREFIX;
         end else if (!(is_dec || is_low || is_up)) begin
            skipping_in = 1'b1;
            emit        = 1'b1;
            status_in   = STATUS_BAD_CHAR;
         end else if (digit >= base_now) begin
            skipping_in = 1'b1;
            emit        = 1'b1;
            status_in   = STATUS_BIG_DIGIT;
         end else begin
            accum_in          = product[VALUE_W-1:0] + VALUE_W'(digit);
            first_was_zero_in = (position_ff == '0) && (ch_ff == CHAR_ZERO);
            if (position_ff != OFFSET_MAX) begin
               position_in = position_ff + OFFSET_W'(1);
            end
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_reg_ff       <= '0;
         in_valid_ff       <= 1'b0;
         accum_ff          <= '0;
         active_base_ff    <= '0;
         position_ff       <= '0;
         first_was_zero_ff <= 1'b0;
         skipping_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            base_reg_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            accum_ff          <= accum_in;
            active_base_ff    <= active_base_in;
            position_ff       <= position_in;
            first_was_zero_ff <= first_was_zero_in;
            skipping_ff       <= skipping_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         ch_ff <= req_ch;
      end
      if (fire && emit) begin
         rsp_value_ff  <= accum_ff;
         rsp_status_ff <= status_in;
         rsp_offset_ff <= position_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_end_offset = rsp_offset_ff;

   // A result beat is never overwritten before the sink takes it.
   assert property (@(posedge clock) disable iff (reset)
      (fire && emit) |-> out_free)
      else $error("result register overwritten while held");

   // An error result always puts the parser into skip mode.
   assert property (@(posedge clock) disable iff (reset)
      (fire && emit && (status_in == STATUS_BAD_CHAR || status_in == STATUS_BIG_DIGIT))
      |=> skipping_ff)
      else $error("error result without skip mode");

   // An empty-string result reports no characters consumed.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_EMPTY) |-> (rsp_offset_ff == '0))
      else $error("empty result with non-zero offset");

   // The leading-zero flag only survives directly after the first character.
   assert property (@(posedge clock) disable iff (reset)
      first_was_zero_ff |-> (position_ff == OFFSET_W'(1) && !skipping_ff))
      else $error("leading-zero flag out of place");

endmodule

`default_nettype wire
